### sv/sbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbs_pkg: shared types and constants of the shuffle buffer
// Slot geometry, splitmix64 constants, status codes, request/result structs.
// ----------------------------------------------------------------------------
package sbs_pkg;

	localparam int SLOT_DEPTH = 1024;
	localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
	localparam int CAP_W      = 11;
	localparam int ITEM_W     = 64;
	localparam int APB_AW     = 4;
	localparam int APB_DW     = 64;

	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

	localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX_A  = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_B  = 64'h94D049BB133111EB;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_CLOSED    = 2'd1;
	localparam logic [1:0] ST_EXHAUSTED = 2'd2;
	localparam logic [1:0] ST_BAD_INDEX = 2'd3;

	// operation codes
	localparam logic OP_OFFER = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// register select (paddr bit 3)
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic REG_RNG_BASE = 1'b1;

	typedef struct packed {
		logic               operation;
		logic [ITEM_W-1:0]  item;
		logic [SLOT_AW-1:0] drain_index;
	} req_t;

	typedef struct packed {
		logic [ITEM_W-1:0] out_item;
		logic              out_valid;
		logic [1:0]        status;
		logic [CAP_W-1:0]  fill_level;
		logic [CAP_W-1:0]  peak_fill;
		logic [63:0]       offered_total;
		logic [63:0]       emitted_total;
		logic              is_closed;
	} res_t;

	// draw unit control
	typedef struct packed {
		logic             start;
		logic [CAP_W-1:0] cap;
		logic [63:0]      base;
		logic [63:0]      count;
	} rng_req_t;

	typedef struct packed {
		logic               done;
		logic               ok;
		logic [SLOT_AW-1:0] slot;
		logic [63:0]        count;
	} rng_res_t;

endpackage
`default_nettype wire

### sv/sbs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbs_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sbs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### sv/sbs_rng.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbs_rng: iterative splitmix64 slot draw
// One shared 32x32 multiplier builds each 64-bit product from partial products; one
// 2-bit-per-cycle divider gives the rejection bound and the final modulo.
// ----------------------------------------------------------------------------
module sbs_rng (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sbs_pkg::rng_req_t rq,
	output sbs_pkg::rng_res_t      rs
);
	import sbs_pkg::*;

	typedef enum logic [5:0] {
		R_IDLE = 6'b000001,
		R_DIV  = 6'b000010,
		R_CHK  = 6'b000100,
		R_MUL  = 6'b001000,
		R_POST = 6'b010000,
		R_DONE = 6'b100000
	} rstate_t;

	rstate_t          state_q;
	logic [CAP_W-1:0] cap_q, rem_q, r_q;
	logic [63:0]      base_q, cnt_q, a_q, b_q, acc_q, p_q, dvd_q;
	logic [1:0]       k_q, phase_q;
	logic [4:0]       dcnt_q;
	logic             div_mod_q, ok_q;

	// divider: two restoring steps per cycle
	logic [CAP_W:0]   t1, t2;
	logic [CAP_W-1:0] r1, r2, r2p;
	always_comb begin
		t1 = {r_q, dvd_q[63]};
		r1 = (t1 >= {1'b0, cap_q}) ? CAP_W'(t1 - {1'b0, cap_q}) : CAP_W'(t1);
		t2 = {r1, dvd_q[62]};
		r2 = (t2 >= {1'b0, cap_q}) ? CAP_W'(t2 - {1'b0, cap_q}) : CAP_W'(t2);
		r2p = r2 + CAP_W'(1);
	end

	// shared multiplier operand select
	logic [31:0] mx, my;
	always_comb begin
		case (k_q)
			2'd1:    begin mx = a_q[63:32]; my = b_q[31:0];  end
			2'd2:    begin mx = a_q[31:0];  my = b_q[63:32]; end
			default: begin mx = a_q[31:0];  my = b_q[31:0];  end
		endcase
	end

	// post-multiply mixing
	logic [63:0] v0, vfin;
	logic [64:0] vsum;
	always_comb begin
		v0   = base_q + acc_q;
		vfin = acc_q ^ (acc_q >> 31);
		vsum = {1'b0, vfin} + {54'b0, rem_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= R_IDLE;
			k_q       <= '0;
			phase_q   <= '0;
			dcnt_q    <= '0;
			div_mod_q <= 1'b0;
			ok_q      <= 1'b0;
		end else begin
			unique case (state_q)
				R_IDLE: begin
					if (rq.start) begin
						cap_q     <= rq.cap;
						base_q    <= rq.base;
						cnt_q     <= rq.count;
						dvd_q     <= '1;
						r_q       <= '0;
						dcnt_q    <= '0;
						div_mod_q <= 1'b0;
						state_q   <= R_DIV;
					end
				end
				R_DIV: begin
					dvd_q  <= dvd_q << 2;
					r_q    <= r2;
					dcnt_q <= dcnt_q + 5'd1;
					if (dcnt_q == 5'd31) begin
						if (div_mod_q) begin
							ok_q    <= 1'b1;
							state_q <= R_DONE;
						end else begin
							// 2^64 mod cap from (2^64-1) mod cap
							rem_q   <= (r2p == cap_q) ? '0 : r2p;
							state_q <= R_CHK;
						end
					end
				end
				R_CHK: begin
					if (cnt_q[63]) begin
						ok_q    <= 1'b0;
						state_q <= R_DONE;
					end else begin
						a_q     <= cnt_q;
						b_q     <= GOLDEN;
						phase_q <= 2'd0;
						k_q     <= 2'd0;
						state_q <= R_MUL;
					end
				end
				R_MUL: begin
					p_q <= mx * my;
					case (k_q)
						2'd1:    acc_q <= p_q;
						2'd2,
						2'd3:    acc_q <= acc_q + {p_q[31:0], 32'b0};
						default: ;
					endcase
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						state_q <= R_POST;
					end
				end
				R_POST: begin
					k_q <= 2'd0;
					case (phase_q)
						2'd0: begin
							a_q     <= v0 ^ (v0 >> 30);
							b_q     <= MIX_A;
							phase_q <= 2'd1;
							state_q <= R_MUL;
						end
						2'd1: begin
							a_q     <= acc_q ^ (acc_q >> 27);
							b_q     <= MIX_B;
							phase_q <= 2'd2;
							state_q <= R_MUL;
						end
						default: begin
							cnt_q <= cnt_q + 64'd1;
							// accept when v + rem does not wrap
							if (rem_q == '0 || !vsum[64]) begin
								dvd_q     <= vfin;
								r_q       <= '0;
								dcnt_q    <= '0;
								div_mod_q <= 1'b1;
								state_q   <= R_DIV;
							end else begin
								state_q <= R_CHK;
							end
						end
					endcase
				end
				R_DONE: begin
					state_q <= R_IDLE;
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	assign rs.done  = (state_q == R_DONE);
	assign rs.ok    = ok_q;
	assign rs.slot  = r_q[SLOT_AW-1:0];
	assign rs.count = cnt_q;

endmodule
`default_nettype wire

### sv/shuffle_buffer_splitmix.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shuffle_buffer_splitmix: shuffle buffer with splitmix64 eviction
// Fill offers and rejected requests finish when accepted, result in the next cycle.
// Evicting offers run the divider for the bound, a multiply/mix pass per draw (each
// rejected value adds another pass), the divider again for the slot, a handoff, then
// reads of the slot and tail and writes of both; drain reads pass the seen-map check.
// Results cannot be stalled. After reset the seen map is cleared while busy is high.
// ----------------------------------------------------------------------------
module shuffle_buffer_splitmix (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire sbs_pkg::req_t              req,
	output sbs_pkg::res_t                   res,
	output logic                            res_valid,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [sbs_pkg::APB_AW-1:0] paddr,
	input  wire logic [sbs_pkg::APB_DW-1:0] pwdata,
	output logic      [sbs_pkg::APB_DW-1:0] prdata,
	output logic                            pready
);
	import sbs_pkg::*;

	typedef enum logic [7:0] {
		S_CLEAR = 8'b00000001,
		S_IDLE  = 8'b00000010,
		S_DRAW  = 8'b00000100,
		S_RD1   = 8'b00001000,
		S_RD2   = 8'b00010000,
		S_WR1   = 8'b00100000,
		S_WR2   = 8'b01000000,
		S_SEEN  = 8'b10000000
	} state_t;

	state_t             state_q;
	logic [CAP_W-1:0]   cap_q, occ_q, peak_q, drained_q;
	logic [63:0]        base_q, cnt_q, offered_q, emitted_q;
	logic               closed_q;
	logic [SLOT_AW-1:0] clr_q, didx_q, slot_q;
	logic [ITEM_W-1:0]  item_q, out_item_q;
	logic               out_valid_q, res_valid_q;
	logic [1:0]         status_q;

	// effective capacity and tail
	logic [CAP_W-1:0]   eff_cap, occ_inc, drn_inc;
	logic [SLOT_AW-1:0] tail;
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CAP_W'(1);
		end else if (cap_q > CAP_W'(SLOT_DEPTH)) begin
			eff_cap = CAP_W'(SLOT_DEPTH);
		end else begin
			eff_cap = cap_q;
		end
		occ_inc = occ_q + CAP_W'(1);
		drn_inc = drained_q + CAP_W'(1);
		tail    = SLOT_AW'(occ_q - CAP_W'(1));
	end

	logic accept, do_fill, do_draw;
	always_comb begin
		accept  = start && (state_q == S_IDLE);
		do_fill = accept && (req.operation == OP_OFFER) && !closed_q &&
			(drained_q == '0) && (occ_q < eff_cap);
		do_draw = accept && (req.operation == OP_OFFER) && !closed_q &&
			(drained_q == '0) && (occ_q >= eff_cap);
	end

	// draw unit
	rng_req_t rq;
	rng_res_t rs;
	assign rq.start = do_draw;
	assign rq.cap   = eff_cap;
	assign rq.base  = base_q;
	assign rq.count = cnt_q;

	sbs_rng u_rng (
		.clk    (clk),
		.arst_n (arst_n),
		.rq     (rq),
		.rs     (rs)
	);

	// slot store and seen map ports
	logic               s_we, n_we, n_wdata, n_rdata;
	logic [SLOT_AW-1:0] s_waddr, s_raddr, n_waddr;
	logic [ITEM_W-1:0]  s_wdata, s_rdata;
	always_comb begin
		s_we    = 1'b0;
		s_waddr = occ_q[SLOT_AW-1:0];
		s_wdata = req.item;
		s_raddr = req.drain_index;
		n_we    = 1'b0;
		n_waddr = didx_q;
		n_wdata = 1'b1;
		unique case (state_q)
			S_CLEAR: begin
				n_we    = 1'b1;
				n_waddr = clr_q;
				n_wdata = 1'b0;
			end
			S_IDLE:  s_we = do_fill;
			S_RD1:   s_raddr = slot_q;
			S_RD2:   s_raddr = tail;
			S_WR1: begin
				s_we    = 1'b1;
				s_waddr = slot_q;
				s_wdata = s_rdata;
			end
			S_WR2: begin
				s_we    = 1'b1;
				s_waddr = tail;
				s_wdata = item_q;
			end
			S_SEEN:  n_we = !n_rdata;
			default: ;
		endcase
	end

	sbs_ram #(.WIDTH(ITEM_W), .DEPTH(SLOT_DEPTH)) u_slots (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	sbs_ram #(.WIDTH(1), .DEPTH(SLOT_DEPTH)) u_seen (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_waddr),
		.wdata (n_wdata),
		.raddr (req.drain_index),
		.rdata (n_rdata)
	);

	// sequencer and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cap_q       <= CAP_RESET;
			base_q      <= '0;
			occ_q       <= '0;
			peak_q      <= '0;
			drained_q   <= '0;
			cnt_q       <= '0;
			offered_q   <= '0;
			emitted_q   <= '0;
			closed_q    <= 1'b0;
			res_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
		end else begin
			res_valid_q <= 1'b0;

			// register write
			if (psel && penable && pwrite) begin
				if (paddr[3] == REG_RNG_BASE) begin
					base_q <= pwdata;
				end else begin
					cap_q <= pwdata[CAP_W-1:0];
				end
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + SLOT_AW'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						item_q      <= req.item;
						didx_q      <= req.drain_index;
						out_item_q  <= '0;
						out_valid_q <= 1'b0;
						status_q    <= ST_OK;
						if (req.operation == OP_OFFER) begin
							if (do_fill) begin
								occ_q       <= occ_inc;
								offered_q   <= offered_q + 64'd1;
								if (occ_inc > peak_q) begin
									peak_q <= occ_inc;
								end
								res_valid_q <= 1'b1;
							end else if (do_draw) begin
								state_q <= S_DRAW;
							end else begin
								status_q    <= ST_CLOSED;
								res_valid_q <= 1'b1;
							end
						end else begin
							if (closed_q) begin
								status_q    <= ST_CLOSED;
								res_valid_q <= 1'b1;
							end else if (occ_q == '0) begin
								closed_q    <= 1'b1;
								res_valid_q <= 1'b1;
							end else if ({1'b0, req.drain_index} >= occ_q) begin
								status_q    <= ST_BAD_INDEX;
								res_valid_q <= 1'b1;
							end else begin
								state_q <= S_SEEN;
							end
						end
					end
				end
				S_DRAW: begin
					if (rs.done) begin
						if (rs.ok) begin
							cnt_q   <= rs.count;
							slot_q  <= rs.slot;
							state_q <= S_RD1;
						end else begin
							status_q    <= ST_EXHAUSTED;
							res_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end
					end
				end
				S_RD1: state_q <= S_RD2;
				S_RD2: begin
					out_item_q <= s_rdata;
					state_q    <= S_WR1;
				end
				S_WR1: state_q <= S_WR2;
				S_WR2: begin
					out_valid_q <= 1'b1;
					offered_q   <= offered_q + 64'd1;
					emitted_q   <= emitted_q + 64'd1;
					res_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_SEEN: begin
					if (n_rdata) begin
						status_q <= ST_BAD_INDEX;
					end else begin
						out_item_q  <= s_rdata;
						out_valid_q <= 1'b1;
						emitted_q   <= emitted_q + 64'd1;
						// last unread slot closes the store
						if (drn_inc >= occ_q) begin
							occ_q     <= '0;
							drained_q <= '0;
							closed_q  <= 1'b1;
						end else begin
							drained_q <= drn_inc;
						end
					end
					res_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

	// result: counters reflect the state after the request
	assign res_valid         = res_valid_q;
	assign res.out_item      = out_item_q;
	assign res.out_valid     = out_valid_q;
	assign res.status        = status_q;
	assign res.fill_level    = occ_q;
	assign res.peak_fill     = peak_q;
	assign res.offered_total = offered_q;
	assign res.emitted_total = emitted_q;
	assign res.is_closed     = closed_q;

	// register read
	assign prdata = (paddr[3] == REG_RNG_BASE) ? base_q :
		{{(APB_DW-CAP_W){1'b0}}, cap_q};
	assign pready = 1'b1;

endmodule
`default_nettype wire

### bench/tb_shuffle_buffer_splitmix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shuffle_buffer_splitmix: self-checking bench for the shuffle buffer
// Fills and evicts under a series of capacity/seed settings written over APB,
// then drains every slot to close. Every request is predicted by a local model
// of the buffer and its splitmix64 draw, and each result is compared per field.
// ----------------------------------------------------------------------------
module tb_shuffle_buffer_splitmix;
	import sbs_pkg::*;

	localparam logic [APB_AW-1:0] CAP_ADDR  = {REG_CAPACITY, 3'b000};
	localparam logic [APB_AW-1:0] BASE_ADDR = {REG_RNG_BASE, 3'b000};
	localparam logic [63:0]       COUNT_END = 64'h8000_0000_0000_0000;
	localparam int                IDLE_LIMIT = 8000;
	localparam int                QUIET_TAIL = 150;

	typedef struct {
		bit                is_cfg;
		req_t              req;
		logic [APB_AW-1:0] addr;
		logic [63:0]       data;
	} pending_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	req_t              req = '0;
	res_t              res;
	logic              res_valid;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	shuffle_buffer_splitmix DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.res(res), .res_valid(res_valid), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// buffer model state
	logic [63:0] slots [SLOT_DEPTH];
	bit          seen [SLOT_DEPTH];
	int          occ, drained, peak;
	logic [63:0] draw_count, offered, emitted;
	bit          closed;
	logic [10:0] cap_reg = CAP_RESET;
	logic [63:0] base_reg = '0;

	pending_t pending [$];
	res_t     expected_results [$];
	int       total_reqs, sent_reqs, gap, settle, idle_cycles, errors;
	int       n_evict, n_drain, n_bad, n_closed, n_cfg, n_results;
	bit       timed_out;

	// splitmix64 slot draw with rejection of biased values
	function automatic bit draw_slot(input logic [63:0] upper, inout logic [63:0] cnt,
			output logic [63:0] slot);
		logic [63:0] rem, lim, v, c;
		rem = (64'd0 - upper) % upper;
		lim = 64'd0 - rem;
		c = cnt;
		slot = '0;
		forever begin
			if (c >= COUNT_END)
				return 1'b0;
			v = base_reg + c * GOLDEN;
			c = c + 1;
			v = (v ^ (v >> 30)) * MIX_A;
			v = (v ^ (v >> 27)) * MIX_B;
			v = v ^ (v >> 31);
			if (rem == 0 || v < lim) begin
				cnt = c;
				slot = v % upper;
				return 1'b1;
			end
		end
	endfunction

	// work out the result of one accepted request and queue it
	task automatic predict_result(input req_t r);
		res_t        e;
		logic [63:0] cap, c, s;
		int          tail, si;
		e = '0;
		e.status = ST_OK;
		cap = (cap_reg == 0) ? 64'd1 : (cap_reg > SLOT_DEPTH) ? 64'(SLOT_DEPTH) : 64'(cap_reg);
		if (r.operation == OP_OFFER) begin
			if (closed || drained != 0) begin
				e.status = ST_CLOSED;
				n_closed++;
			end else if (occ < cap) begin
				slots[occ] = r.item;
				occ++;
				offered++;
				if (occ > peak) peak = occ;
			end else begin
				c = draw_count;
				if (!draw_slot(cap, c, s)) begin
					e.status = ST_EXHAUSTED;
				end else begin
					tail = occ - 1;
					si = int'(s);
					draw_count = c;
					e.out_item = slots[si];
					e.out_valid = 1'b1;
					slots[si] = slots[tail];
					slots[tail] = r.item;
					offered++;
					emitted++;
					n_evict++;
				end
			end
		end else begin
			if (closed) begin
				e.status = ST_CLOSED;
				n_closed++;
			end else if (occ == 0) begin
				closed = 1'b1;
			end else if (r.drain_index >= occ || seen[r.drain_index]) begin
				e.status = ST_BAD_INDEX;
				n_bad++;
			end else begin
				seen[r.drain_index] = 1'b1;
				e.out_item = slots[r.drain_index];
				e.out_valid = 1'b1;
				emitted++;
				drained++;
				n_drain++;
				if (drained >= occ) begin
					occ = 0;
					drained = 0;
					closed = 1'b1;
				end
			end
		end
		e.fill_level = occ[CAP_W-1:0];
		e.peak_fill = peak[CAP_W-1:0];
		e.offered_total = offered;
		e.emitted_total = emitted;
		e.is_closed = closed;
		expected_results.insert(expected_results.size(), e);
	endtask

	task automatic add_req(input logic op, input logic [63:0] item, input int idx);
		pending_t p;
		p.is_cfg = 1'b0;
		p.req.operation = op;
		p.req.item = item;
		p.req.drain_index = idx[SLOT_AW-1:0];
		p.addr = '0;
		p.data = '0;
		pending.insert(pending.size(), p);
		total_reqs++;
	endtask

	task automatic add_cfg(input logic [APB_AW-1:0] a, input logic [63:0] d);
		pending_t p;
		p.is_cfg = 1'b1;
		p.req = '0;
		p.addr = a;
		p.data = d;
		pending.insert(pending.size(), p);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// driver: requests and register writes
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predict_result(req);
				sent_reqs++;
				if (sent_reqs < total_reqs - QUIET_TAIL && $urandom_range(0, 5) == 0)
					gap = $urandom_range(1, 12);
			end
			if (expected_results.size() == 0 && !start && !busy && !psel)
				settle++;
			else
				settle = 0;

			if (psel && penable && pready) begin
				// write lands at this edge
				if (paddr == CAP_ADDR)
					cap_reg = pwdata[10:0];
				else
					base_reg = pwdata;
				n_cfg++;
				psel <= 1'b0;
				penable <= 1'b0;
			end else if (psel) begin
				penable <= 1'b1;
			end else if (start && busy) begin
				// hold request until taken
			end else if (gap > 0) begin
				gap--;
				start <= 1'b0;
			end else if (pending.size() == 0) begin
				start <= 1'b0;
			end else if (!pending[0].is_cfg) begin
				req <= pending[0].req;
				start <= 1'b1;
				pending.delete(0);
			end else begin
				start <= 1'b0;
				if (!start && settle >= 8) begin
					psel <= 1'b1;
					pwrite <= 1'b1;
					paddr <= pending[0].addr;
					pwdata <= pending[0].data;
					pending.delete(0);
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: mismatch in %s: expected %h, got %h", $time, name, exp_v, got_v);
			errors++;
		end
	endtask

	// monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && res_valid) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, res);
				errors++;
			end else begin
				res_t e;
				e = expected_results[0];
				expected_results.delete(0);
				check_field("out_item", e.out_item, res.out_item);
				check_field("out_valid", e.out_valid, res.out_valid);
				check_field("status", e.status, res.status);
				check_field("fill_level", e.fill_level, res.fill_level);
				check_field("peak_fill", e.peak_fill, res.peak_fill);
				check_field("offered_total", e.offered_total, res.offered_total);
				check_field("emitted_total", e.emitted_total, res.emitted_total);
				check_field("is_closed", e.is_closed, res.is_closed);
			end
			n_results++;
		end
	end

	// watchdog on cycles with no progress
	always @(posedge clk) begin
		if ((start && !busy) || res_valid || psel)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		int          gen_occ, eff, n, k, tmp, idx;
		int          order [$];
		logic [10:0] c;
		gen_occ = 0;

		// directed: capacity 0 acts as 1, seed 0, item extremes, bad indexes
		add_cfg(CAP_ADDR, 64'd0);
		add_cfg(BASE_ADDR, 64'd0);
		add_req(OP_OFFER, 64'd0, 0);
		add_req(OP_DRAIN, '0, 1023);
		add_req(OP_DRAIN, '0, 1);
		add_req(OP_OFFER, '1, 0);
		add_req(OP_OFFER, 64'h5555_5555_5555_5555, 0);
		add_req(OP_OFFER, 64'hAAAA_AAAA_AAAA_AAAA, 0);
		gen_occ = 1;
		// capacity above depth acts as depth, seed all ones
		add_cfg(CAP_ADDR, 64'd2047);
		add_cfg(BASE_ADDR, '1);
		for (int i = 0; i < 6; i++)
			add_req(OP_OFFER, rand64(), 0);
		gen_occ += 6;
		// capacity lowered below occupancy: every offer evicts
		add_cfg(CAP_ADDR, 64'd3);
		for (int i = 0; i < 6; i++)
			add_req(OP_OFFER, rand64(), 0);
		add_req(OP_DRAIN, '0, 1023);

		// random phases of fill and eviction
		while (total_reqs < 850) begin
			tmp = $urandom_range(0, 9);
			c = (tmp == 0) ? 11'd1 : (tmp == 1) ? 11'd1024 : (tmp == 2) ? 11'd0 :
				11'($urandom_range(1, 60));
			add_cfg(CAP_ADDR, 64'(c));
			if ($urandom_range(0, 1))
				add_cfg(BASE_ADDR, rand64());
			eff = (c == 0) ? 1 : (c > SLOT_DEPTH) ? SLOT_DEPTH : c;
			n = $urandom_range(20, 70);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 19) == 0 && gen_occ < SLOT_DEPTH) begin
					add_req(OP_DRAIN, rand64(), $urandom_range(gen_occ, SLOT_DEPTH - 1));
				end else begin
					add_req(OP_OFFER, rand64(), $urandom_range(0, SLOT_DEPTH - 1));
					if (gen_occ < eff) gen_occ++;
				end
			end
		end

		// drain: a shuffled order of all slots mixed with repeats, bad indexes, offers
		for (int i = 0; i < gen_occ; i++) order.insert(order.size(), i);
		order.shuffle();
		for (int i = 0; i < gen_occ; i++) begin
			add_req(OP_DRAIN, rand64(), order[i]);
			k = $urandom_range(0, 7);
			if (k == 0)
				add_req(OP_DRAIN, rand64(), order[$urandom_range(0, i)]);
			else if (k == 1 && gen_occ < SLOT_DEPTH)
				add_req(OP_DRAIN, rand64(), $urandom_range(gen_occ, SLOT_DEPTH - 1));
			else if (k == 2 && i + 1 < gen_occ)
				add_req(OP_OFFER, rand64(), 0);
		end
		// closed: offers and drains are refused
		for (int i = 0; i < 20; i++) begin
			idx = $urandom_range(0, SLOT_DEPTH - 1);
			add_req(1'($urandom_range(0, 1)), rand64(), idx);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending.size() == 0 && sent_reqs == total_reqs && expected_results.size() == 0);
		repeat (200) @(posedge clk);
		$display("Covered %0d requests: %0d evictions, %0d drain reads, %0d bad indexes,",
			total_reqs, n_evict, n_drain, n_bad);
		$display("%0d refused while closed, %0d register writes, %0d results checked.",
			n_closed, n_cfg, n_results);
		if (errors == 0 && expected_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### filelist.f
sv/sbs_pkg.sv
sv/sbs_ram.sv
sv/sbs_rng.sv
sv/shuffle_buffer_splitmix.sv
bench/tb_shuffle_buffer_splitmix.sv
